[src/rmeg_pkg.sv]
// Shared types and constants for the random matrix element generator.
package rmeg_pkg;

	// Configuration register map (8-byte spacing)
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned DATA_W  = 64;

	typedef enum logic [1:0] {
		REG_FIELD_ORDER  = 2'd0,
		REG_ROW_COUNT    = 2'd1,
		REG_COLUMN_COUNT = 2'd2,
		REG_SEED_VALUE   = 2'd3
	} reg_idx_t;

	// Generator constants
	localparam logic [63:0] SHIFT_TAPS = 64'h0000_0003_b4f0_bf89;
	localparam logic [10:0] MUL_A      = 11'd1021;
	localparam logic [19:0] MOD_A      = 20'd1000003;
	localparam logic [11:0] MUL_B      = 12'd2063;
	localparam logic [19:0] MOD_B      = 20'd1000037;

	// Lehmer reduction: byte weights 2^(8i) mod m fold 64 bits to 31,
	// then a reciprocal quotient and one correction give the remainder
	localparam int unsigned RCP_SHIFT = 50;
	localparam logic [7:0][19:0] WGT_A = {
		20'((64'd1 << 56) % {44'd0, MOD_A}),
		20'((64'd1 << 48) % {44'd0, MOD_A}),
		20'((64'd1 << 40) % {44'd0, MOD_A}),
		20'((64'd1 << 32) % {44'd0, MOD_A}),
		20'((64'd1 << 24) % {44'd0, MOD_A}),
		20'((64'd1 << 16) % {44'd0, MOD_A}),
		20'((64'd1 << 8) % {44'd0, MOD_A}),
		20'(64'd1 % {44'd0, MOD_A})
	};
	localparam logic [7:0][19:0] WGT_B = {
		20'((64'd1 << 56) % {44'd0, MOD_B}),
		20'((64'd1 << 48) % {44'd0, MOD_B}),
		20'((64'd1 << 40) % {44'd0, MOD_B}),
		20'((64'd1 << 32) % {44'd0, MOD_B}),
		20'((64'd1 << 24) % {44'd0, MOD_B}),
		20'((64'd1 << 16) % {44'd0, MOD_B}),
		20'((64'd1 << 8) % {44'd0, MOD_B}),
		20'(64'd1 % {44'd0, MOD_B})
	};
	localparam logic [30:0] RCP_A = 31'((64'd1 << RCP_SHIFT) / {44'd0, MOD_A});
	localparam logic [30:0] RCP_B = 31'((64'd1 << RCP_SHIFT) / {44'd0, MOD_B});

	localparam int unsigned CNT_W      = 6;
	localparam logic [CNT_W-1:0] QMOD_LAST = CNT_W'(63);

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FOLD,
		ST_QUOT,
		ST_LREM,
		ST_SUM,
		ST_QMOD,
		ST_DONE
	} state_t;

	// Per-state control strobes
	typedef struct packed {
		logic in_ready;
		logic mul_en;
		logic fold_en;
		logic quot_en;
		logic lrem_en;
		logic sum_en;
		logic qmod_en;
		logic done;
	} ctrl_t;

endpackage

[src/random_matrix_element_generator_unit.sv]
// Top level: sequenced pseudo-random matrix element generator with APB configuration.
//
// Usage:
//   Each input transaction (restart bit) requests one matrix element; each output
//   transaction carries element, row_index, col_index, row_end and matrix_end in
//   row-major order. restart=1 reseeds the three generators from seed_value and
//   returns to row 0, column 0 before the element is produced.
//   Configuration goes through the APB port (8-byte spacing, 64-bit data); pready is
//   always high. Configuration is to be written only while the block is idle; the
//   user is bound by this, and the block itself does not enforce it.
// Sequencing:
//   Identity-part elements (column below row count) go from accept straight to the
//   done state, which loads the output register. Random elements pass through
//   constant products, Lehmer reduction (byte fold, reciprocal quotient, remainder
//   with one correction), summing, bit-serial reduction by field_order in one shared
//   65-bit compare/subtract unit, and the load of the output. With field_order zero
//   the reduction is skipped. One element is in work at a time; in_ready is high
//   only while the sequencer is idle.
// Reset and stalls:
//   arst_n clears the generators, position and configuration to their defaults.
//   A finished element sits in the output register; while the receiver stalls, the
//   next request may be accepted and computed, then waits until the register frees.
module random_matrix_element_generator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rmeg_pkg::PADDR_W-1:0]    paddr,
	input  logic [rmeg_pkg::DATA_W-1:0]     pwdata,
	output logic [rmeg_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	// request channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            restart,
	// element channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [63:0]                     element,
	output logic [31:0]                     row_index,
	output logic [31:0]                     col_index,
	output logic                            row_end,
	output logic                            matrix_end
);
	import rmeg_pkg::*;

	// Weighted byte sum: congruent to x modulo the weights' modulus, below 2^31
	function automatic logic [30:0] byte_fold(input logic [63:0] x,
			input logic [7:0][19:0] wgt);
		logic [30:0] acc;
		acc = '0;
		for (int i = 0; i < 8; i++) begin
			acc = acc + ({23'd0, x[8*i +: 8]} * {11'd0, wgt[i]});
		end
		return acc;
	endfunction

	// Configuration registers
	logic [63:0] field_order_q;
	logic [31:0] row_count_q;
	logic [31:0] column_count_q;
	logic [63:0] seed_value_q;

	// Generator and position state
	logic [63:0] shift_gen_q;
	logic [63:0] lehmer_a_q;
	logic [63:0] lehmer_b_q;
	logic [31:0] cur_row_q;
	logic [31:0] cur_col_q;

	// Datapath registers
	logic [63:0]      div_a_q;
	logic [63:0]      div_b_q;
	logic [30:0]      fold_a_q;
	logic [30:0]      fold_b_q;
	logic [11:0]      quo_a_q;
	logic [11:0]      quo_b_q;
	logic [19:0]      rem_a_q;
	logic [19:0]      rem_b_q;
	logic [63:0]      div_g_q;
	logic [63:0]      elem_q;
	logic [CNT_W-1:0] cnt_q;

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic        in_accept;
	logic        out_free;
	logic        out_load;
	logic [31:0] rows;
	logic [31:0] cols;
	logic [31:0] eff_row;
	logic [31:0] eff_col;
	logic        is_random;
	logic        last_col;
	logic        last_row;
	logic [74:0] prod_a;
	logic [75:0] prod_b;
	logic [61:0] qprod_a;
	logic [61:0] qprod_b;
	logic [30:0] lrem_a;
	logic [30:0] lrem_b;
	logic [19:0] rem_a_next;
	logic [19:0] rem_b_next;
	logic [64:0] q_trial;
	logic [63:0] q_rem_next;
	logic [63:0] g_sum;
	logic        cfg_wr;

	// APB access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (reg_idx_t'(paddr[4:3]))
			REG_FIELD_ORDER:  prdata = field_order_q;
			REG_ROW_COUNT:    prdata = {32'd0, row_count_q};
			REG_COLUMN_COUNT: prdata = {32'd0, column_count_q};
			REG_SEED_VALUE:   prdata = seed_value_q;
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_order_q  <= 64'd2;
			row_count_q    <= 32'd1;
			column_count_q <= 32'd1;
			seed_value_q   <= 64'd0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:3]))
				REG_FIELD_ORDER:  field_order_q  <= pwdata;
				REG_ROW_COUNT:    row_count_q    <= pwdata[31:0];
				REG_COLUMN_COUNT: column_count_q <= pwdata[31:0];
				REG_SEED_VALUE:   seed_value_q   <= pwdata;
				default:          ;
			endcase
		end
	end

	// Position decode; zero counts act as one
	assign rows      = (row_count_q == 32'd0) ? 32'd1 : row_count_q;
	assign cols      = (column_count_q == 32'd0) ? 32'd1 : column_count_q;
	assign eff_row   = restart ? 32'd0 : cur_row_q;
	assign eff_col   = restart ? 32'd0 : cur_col_q;
	assign is_random = (eff_col >= rows);
	assign last_col  = ({1'b0, cur_col_q} + 33'd1) >= {1'b0, cols};
	assign last_row  = ({1'b0, cur_row_q} + 33'd1) >= {1'b0, rows};

	// Constant products, truncated to 64 bits
	assign prod_a = lehmer_a_q * MUL_A;
	assign prod_b = lehmer_b_q * MUL_B;

	// Reciprocal quotient of the folded value; at most one below the true one
	assign qprod_a = {31'd0, fold_a_q} * {31'd0, RCP_A};
	assign qprod_b = {31'd0, fold_b_q} * {31'd0, RCP_B};

	// Remainder below twice the modulus, then one conditional subtract
	assign lrem_a = fold_a_q - ({19'd0, quo_a_q} * {11'd0, MOD_A});
	assign lrem_b = fold_b_q - ({19'd0, quo_b_q} * {11'd0, MOD_B});
	assign rem_a_next = (lrem_a >= {11'd0, MOD_A}) ?
		20'(lrem_a - {11'd0, MOD_A}) : lrem_a[19:0];
	assign rem_b_next = (lrem_b >= {11'd0, MOD_B}) ?
		20'(lrem_b - {11'd0, MOD_B}) : lrem_b[19:0];

	// Shared field-order reduction step
	assign q_trial    = {elem_q, div_g_q[63]};
	assign q_rem_next = (q_trial >= {1'b0, field_order_q}) ?
		64'(q_trial - {1'b0, field_order_q}) : q_trial[63:0];

	assign g_sum = shift_gen_q + {44'd0, rem_a_q} + {44'd0, rem_b_q};

	// Handshakes
	assign in_accept = in_valid && ctrl.in_ready;
	assign out_free  = !out_valid || out_ready;
	assign out_load  = ctrl.done && out_free;
	assign in_ready  = ctrl.in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = is_random ? ST_MUL : ST_DONE;
			ST_MUL:  state_d = ST_FOLD;
			ST_FOLD: state_d = ST_QUOT;
			ST_QUOT: state_d = ST_LREM;
			ST_LREM: state_d = ST_SUM;
			ST_SUM:  state_d = (field_order_q == 64'd0) ? ST_DONE : ST_QMOD;
			ST_QMOD: if (cnt_q == QMOD_LAST) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control strobes per state
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE: ctrl.in_ready = 1'b1;
			ST_MUL:  ctrl.mul_en   = 1'b1;
			ST_FOLD: ctrl.fold_en  = 1'b1;
			ST_QUOT: ctrl.quot_en  = 1'b1;
			ST_LREM: ctrl.lrem_en  = 1'b1;
			ST_SUM:  ctrl.sum_en   = 1'b1;
			ST_QMOD: ctrl.qmod_en  = 1'b1;
			ST_DONE: ctrl.done     = 1'b1;
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Generators and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_gen_q <= '0;
			lehmer_a_q  <= '0;
			lehmer_b_q  <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			cnt_q       <= '0;
		end else begin
			if (in_accept && restart) begin
				shift_gen_q <= seed_value_q;
				lehmer_a_q  <= seed_value_q;
				lehmer_b_q  <= seed_value_q;
				cur_row_q   <= '0;
				cur_col_q   <= '0;
			end
			if (ctrl.mul_en) begin
				shift_gen_q <= {shift_gen_q[62:0], 1'b0} ^
					(shift_gen_q[63] ? SHIFT_TAPS : 64'd0);
			end
			if (ctrl.qmod_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (ctrl.sum_en) begin
				lehmer_a_q <= {44'd0, rem_a_q};
				lehmer_b_q <= {44'd0, rem_b_q};
				cnt_q      <= '0;
			end
			// advance position as the element leaves
			if (out_load) begin
				if (last_col) begin
					cur_col_q <= '0;
					cur_row_q <= last_row ? 32'd0 : cur_row_q + 32'd1;
				end else begin
					cur_col_q <= cur_col_q + 32'd1;
				end
			end
		end
	end

	// Reduction datapath
	always_ff @(posedge clk) begin
		if (in_accept) begin
			elem_q <= {63'd0, (eff_col == eff_row)};
		end
		if (ctrl.mul_en) begin
			div_a_q <= prod_a[63:0];
			div_b_q <= prod_b[63:0];
		end
		if (ctrl.fold_en) begin
			fold_a_q <= byte_fold(div_a_q, WGT_A);
			fold_b_q <= byte_fold(div_b_q, WGT_B);
		end
		if (ctrl.quot_en) begin
			quo_a_q <= 12'(qprod_a >> RCP_SHIFT);
			quo_b_q <= 12'(qprod_b >> RCP_SHIFT);
		end
		if (ctrl.lrem_en) begin
			rem_a_q <= rem_a_next;
			rem_b_q <= rem_b_next;
		end
		if (ctrl.sum_en) begin
			div_g_q <= g_sum;
			elem_q  <= (field_order_q == 64'd0) ? g_sum : 64'd0;
		end
		if (ctrl.qmod_en) begin
			elem_q  <= q_rem_next;
			div_g_q <= {div_g_q[62:0], 1'b0};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			element    <= elem_q;
			row_index  <= cur_row_q;
			col_index  <= cur_col_q;
			row_end    <= last_col;
			matrix_end <= last_col && last_row;
		end
	end

endmodule

[verif/testbench.sv]
// Self-checking testbench for the random matrix element generator unit.
`timescale 1ns / 100ps

module testbench;
	import rmeg_pkg::*;

	// Generator constants for the element model
	localparam bit [63:0] LFSR_TAPS = 64'h0000_0003_b4f0_bf89;
	localparam bit [63:0] LCG_A_MUL = 64'd1021;
	localparam bit [63:0] LCG_A_MOD = 64'd1000003;
	localparam bit [63:0] LCG_B_MUL = 64'd2063;
	localparam bit [63:0] LCG_B_MOD = 64'd1000037;
	localparam int unsigned RANDOM_ITEMS = 1800;

	typedef struct packed {
		bit [63:0] element;
		bit [31:0] row;
		bit [31:0] col;
		bit        row_end;
		bit        matrix_end;
	} elem_rec_t;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// DUT ports
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                restart = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [63:0]         element;
	logic [31:0]         row_index;
	logic [31:0]         col_index;
	logic                row_end;
	logic                matrix_end;

	random_matrix_element_generator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.element    (element),
		.row_index  (row_index),
		.col_index  (col_index),
		.row_end    (row_end),
		.matrix_end (matrix_end)
	);

	// Model copy of configuration and generator state
	bit [63:0] q_order = 64'd2;
	bit [31:0] n_rows = 32'd1;
	bit [31:0] n_cols = 32'd1;
	bit [63:0] seed = '0;
	bit [63:0] lfsr_q = '0;
	bit [63:0] lcg_a = '0;
	bit [63:0] lcg_b = '0;
	bit [31:0] pos_row = '0;
	bit [31:0] pos_col = '0;

	bit        request_queue[$];
	elem_rec_t expected_elems[$];
	bit        steady_flow = 1'b0;
	int unsigned fail_count = 0;

	// Step all three generators, return their wrapping sum
	function automatic bit [63:0] advance_generators();
		bit msb;
		msb = lfsr_q[63];
		lfsr_q = lfsr_q << 1;
		if (msb) begin
			lfsr_q = lfsr_q ^ LFSR_TAPS;
		end
		lcg_a = (lcg_a * LCG_A_MUL) % LCG_A_MOD;
		lcg_b = (lcg_b * LCG_B_MUL) % LCG_B_MOD;
		return lfsr_q + lcg_a + lcg_b;
	endfunction

	// Expected element for one accepted request; advances the position
	function automatic elem_rec_t predict_element(bit reseed);
		elem_rec_t rec;
		bit [32:0] rows_eff;
		bit [32:0] cols_eff;
		bit [63:0] g;
		bit        last_col;
		bit        last_row;
		rows_eff = (n_rows == 0) ? 33'd1 : {1'b0, n_rows};
		cols_eff = (n_cols == 0) ? 33'd1 : {1'b0, n_cols};
		if (reseed) begin
			lfsr_q = seed;
			lcg_a = seed;
			lcg_b = seed;
			pos_row = '0;
			pos_col = '0;
		end
		if ({1'b0, pos_col} < rows_eff) begin
			rec.element = (pos_col == pos_row) ? 64'd1 : 64'd0;
		end else begin
			g = advance_generators();
			rec.element = (q_order != 0) ? g % q_order : g;
		end
		last_col = ({1'b0, pos_col} + 33'd1) >= cols_eff;
		last_row = ({1'b0, pos_row} + 33'd1) >= rows_eff;
		rec.row = pos_row;
		rec.col = pos_col;
		rec.row_end = last_col;
		rec.matrix_end = last_col && last_row;
		if (last_col) begin
			pos_col = '0;
			pos_row = last_row ? 32'd0 : pos_row + 32'd1;
		end else begin
			pos_col = pos_col + 32'd1;
		end
		return rec;
	endfunction

	task automatic report_field(string name, bit [63:0] exp_val, bit [63:0] act_val);
		fail_count++;
		$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_val,
			act_val);
	endtask

	// Compare one output transaction with the oldest expectation
	task automatic check_element();
		elem_rec_t exp_rec;
		if (expected_elems.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected element: expected none, actual 0x%0h at (%0d,%0d)",
				$time, element, row_index, col_index);
		end else begin
			exp_rec = expected_elems.pop_front();
			if (element !== exp_rec.element) report_field("element", exp_rec.element, element);
			if (row_index !== exp_rec.row) begin
				report_field("row_index", 64'(exp_rec.row), 64'(row_index));
			end
			if (col_index !== exp_rec.col) begin
				report_field("col_index", 64'(exp_rec.col), 64'(col_index));
			end
			if (row_end !== exp_rec.row_end) begin
				report_field("row_end", 64'(exp_rec.row_end), 64'(row_end));
			end
			if (matrix_end !== exp_rec.matrix_end) begin
				report_field("matrix_end", 64'(exp_rec.matrix_end), 64'(matrix_end));
			end
		end
	endtask

	// Request driver: predicts on acceptance, then presents the next pending request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_elems.push_back(predict_element(restart));
			end
			if (!in_valid || in_ready) begin
				if (request_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 15)) begin
					in_valid <= 1'b1;
					restart <= request_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Element monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				check_element();
			end
			out_ready <= steady_flow || ($urandom_range(99) >= 15);
		end
	end

	// APB register write; model config follows the write edge
	task automatic write_reg(reg_idx_t idx, bit [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FIELD_ORDER:  q_order = value;
			REG_ROW_COUNT:    n_rows = value[31:0];
			REG_COLUMN_COUNT: n_cols = value[31:0];
			REG_SEED_VALUE:   seed = value;
			default:          ;
		endcase
	endtask

	// Hold until every queued request is taken and every element is checked;
	// sampled mid-cycle so that the driver's updates at the edge have settled
	task automatic wait_drained();
		while (request_queue.size() != 0 || in_valid || expected_elems.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Queue a burst of requests and let it drain
	task automatic run_burst(int unsigned n, bit first_restart, int unsigned restart_pct);
		for (int unsigned i = 0; i < n; i++) begin
			if (i == 0) request_queue.push_back(first_restart);
			else request_queue.push_back($urandom_range(99) < restart_pct);
		end
		wait_drained();
	endtask

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit [63:0] pick_order();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return 64'd1;
			2: return 64'd2;
			3: return '1;
			4, 5: return rand64();
			6: return rand64() >> $urandom_range(63);
			default: return 64'($urandom_range(1000, 2));
		endcase
	endfunction

	function automatic bit [31:0] pick_rows();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: return $urandom_range(4, 1);
		endcase
	endfunction

	function automatic bit [31:0] pick_cols(bit [31:0] rows);
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return $urandom;
			default: begin
				if (rows <= 32'd4) return rows + $urandom_range(6, 0);
				return $urandom_range(10, 1);
			end
		endcase
	endfunction

	// Stimulus
	initial begin
		int unsigned issued;
		int unsigned burst_no;
		bit [31:0] rows;
		bit noisy;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset configuration: 1x1 identity
		run_burst(2, 1'b0, 0);

		// Unreduced elements, seed with top bit set, one full matrix
		write_reg(REG_FIELD_ORDER, 64'd0);
		write_reg(REG_ROW_COUNT, 64'd2);
		write_reg(REG_COLUMN_COUNT, 64'd5);
		write_reg(REG_SEED_VALUE, '1);
		run_burst(10, 1'b1, 0);

		// Field of order one, zero row count behaves as one
		write_reg(REG_FIELD_ORDER, 64'd1);
		write_reg(REG_ROW_COUNT, 64'd0);
		write_reg(REG_COLUMN_COUNT, 64'd3);
		run_burst(3, 1'b1, 0);

		// Largest field order, then counts lowered below the current position
		write_reg(REG_FIELD_ORDER, '1);
		write_reg(REG_ROW_COUNT, 64'd3);
		write_reg(REG_COLUMN_COUNT, 64'd6);
		write_reg(REG_SEED_VALUE, rand64());
		run_burst(8, 1'b1, 0);
		write_reg(REG_ROW_COUNT, 64'd1);
		write_reg(REG_COLUMN_COUNT, 64'd2);
		run_burst(2, 1'b0, 0);

		// Random bursts: mostly starting with a restart, some noisy with frequent restarts
		issued = 0;
		burst_no = 0;
		while (issued < RANDOM_ITEMS) begin
			int unsigned n;
			steady_flow = (burst_no >= 6 && burst_no < 12);
			rows = n_rows;
			if (burst_no == 0 || $urandom_range(1)) write_reg(REG_FIELD_ORDER, pick_order());
			if (burst_no == 0 || $urandom_range(1)) begin
				rows = pick_rows();
				write_reg(REG_ROW_COUNT, 64'(rows));
			end
			if (burst_no == 0 || $urandom_range(1)) begin
				write_reg(REG_COLUMN_COUNT, 64'(pick_cols(rows)));
			end
			if (burst_no == 0 || $urandom_range(1)) begin
				case ($urandom_range(7))
					0: write_reg(REG_SEED_VALUE, 64'd0);
					1: write_reg(REG_SEED_VALUE, '1);
					default: write_reg(REG_SEED_VALUE, rand64());
				endcase
			end
			n = $urandom_range(48, 8);
			noisy = ($urandom_range(7) == 0);
			if (noisy) run_burst(n, $urandom_range(1), 40);
			else run_burst(n, $urandom_range(99) < 85, 2);
			issued += n;
			burst_no++;
		end
		steady_flow = 1'b0;

		// Let the last element settle out
		repeat (100) @(posedge clk);
		if (fail_count == 0 && expected_elems.size() == 0) begin
			$display("** random_matrix_element_generator_unit: PASSED **");
		end else begin
			$display("** random_matrix_element_generator_unit: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(20_000_000);
		$display("** random_matrix_element_generator_unit: FAILED **");
		$finish;
	end

endmodule
